@@ rtl/serial_frame_deframer_assert.svh @@
`ifndef SERIAL_FRAME_DEFRAMER_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_ASSERT_SVH

// clocked check, ignored while reset is asserted
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that must also hold while reset is asserted
`define SFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/sfd_pkg.sv @@
package sfd_pkg;

  // field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned TdataW   = 40;
  localparam int unsigned TuserW   = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HEADER = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TAIL   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TARGET = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SOURCE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT  = 3'd4;

  // configuration reset values
  localparam logic [ByteW-1:0] HEADER_RST = 8'd223;
  localparam logic [ByteW-1:0] TAIL_RST   = 8'd253;
  localparam logic [ByteW-1:0] TARGET_RST = 8'd151;
  localparam logic [ByteW-1:0] SOURCE_RST = 8'd1;
  localparam logic [LenW-1:0]  LIMIT_RST  = 6'd60;

  // frame layout offsets
  localparam int unsigned OffTarget  = 1;
  localparam int unsigned OffSource  = 2;
  localparam int unsigned OffClass   = 3;
  localparam int unsigned OffSub     = 4;
  localparam int unsigned OffLen     = 5;
  localparam int unsigned OffPayload = 6;
  localparam int unsigned FrameOvh   = 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_EMIT_RD,
    ST_EMIT_WR
  } sfd_state_e;

endpackage

@@ rtl/sfd_ram.sv @@
module sfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 69
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/serial_frame_deframer.sv @@
// Serial frame deframer.
// Input stream: one received byte per transfer on s_axis. Output stream: one
// transfer per payload byte of each good frame (class, subcode, length, index,
// byte in tdata, tlast on the final byte), or one empty marker transfer
// (tuser high, tlast high) for a frame with no payload.
// Configuration: cfg_we_i writes register cfg_index_i (0 header, 1 tail,
// 2 target address, 3 source address, 4 length limit); write only while the
// block is idle.
// Byte handling: a byte that needs no rescan passes accept, read, evaluate
// and read check. Each byte re-walked after a rejected header adds a read and
// an evaluate, each emitted item an emit read and an emit write; all of this
// is paced by the single read port of the byte store and one shared evaluation
// step. After its high checksum byte is read and evaluated, the first item of a
// good frame passes emit read and emit write, as does each later item.
// tready is low while a byte is evaluated or a frame is emitted.
// Reset empties the byte store (its contents are not cleared, only the fill
// count) and restores the register defaults; no clearing pass is needed.
// When the receiver stalls, the output register holds its transfer and
// emission of the frame waits; bytes are still taken whenever idle.
module serial_frame_deframer #(
  parameter int unsigned MAX_PAYLOAD = 60
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sfd_pkg::ByteW-1:0]  cfg_data_i,
  // received bytes
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [sfd_pkg::ByteW-1:0]  s_axis_tdata_i,  // [7:0] rx_byte
  // payload items
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [7:0] class_code, [15:8] sub_code, [21:16] payload_length,
  // [27:22] byte_index, [35:28] payload_byte, [39:36] zero
  output logic [sfd_pkg::TdataW-1:0] m_axis_tdata_o,
  output logic                       m_axis_tlast_o,   // last_of_frame
  output logic [sfd_pkg::TuserW-1:0] m_axis_tuser_o    // [0] empty_marker
);

  import sfd_pkg::*;

  localparam int unsigned Depth = MAX_PAYLOAD + FrameOvh;
  localparam int unsigned PW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam logic [ByteW-1:0] MaxPayByte = ByteW'(MAX_PAYLOAD);

  // wrap a sum below twice the depth back into the ring
  function automatic logic [PW-1:0] wrap_ptr(input logic [PW:0] sum);
    logic [PW:0] red;
    red = sum - (PW+1)'(Depth);
    wrap_ptr = (sum >= (PW+1)'(Depth)) ? red[PW-1:0] : sum[PW-1:0];
  endfunction

  sfd_state_e state_q, state_d;

  logic [ByteW-1:0] header_q, tail_q, target_q, source_q;
  logic [LenW-1:0]  limit_q;

  logic [PW-1:0]    base_q, base_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    scan_q, scan_d;
  logic [15:0]      sum_q, sum_d;
  logic [ByteW-1:0] class_q, class_d, sub_q, sub_d, len_q, len_d, cklo_q, cklo_d;
  logic [ByteW-1:0] idx_q, idx_d;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_class_q, out_sub_q, out_byte_q;
  logic [LenW-1:0]  out_len_q, out_idx_q;
  logic             out_empty_q, out_last_q;
  logic             out_load;

  logic             in_xfer;
  logic             slot_free;
  logic             mem_we;
  logic [PW-1:0]    mem_waddr, mem_raddr;
  logic [ByteW-1:0] mem_rdata;

  logic             drop_en;
  logic [CW-1:0]    drop_n;
  logic [CW-1:0]    tail_k;
  logic             emit_last;

  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // byte store as a ring starting at the candidate header
  assign mem_we    = in_xfer;
  assign mem_waddr = wrap_ptr({1'b0, base_q} + (PW+1)'(count_q));
  assign mem_raddr = (state_q == ST_READ)
                   ? wrap_ptr({1'b0, base_q} + (PW+1)'(scan_q))
                   : wrap_ptr({1'b0, base_q} + (PW+1)'(OffPayload) + (PW+1)'(idx_q));

  sfd_ram #(
    .WIDTH (ByteW),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign tail_k    = CW'(len_q) + CW'(OffPayload);
  assign emit_last = (len_q == '0) || (idx_q == len_q - 8'd1);

  // sequencer: one stored byte evaluated per read
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    count_d     = count_q;
    scan_d      = scan_q;
    sum_d       = sum_q;
    class_d     = class_q;
    sub_d       = sub_q;
    len_d       = len_q;
    cklo_d      = cklo_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_load    = 1'b0;
    drop_en     = 1'b0;
    drop_n      = CW'(1);

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          count_d = count_q + CW'(1);
          state_d = ST_READ;
        end
        if (cfg_we_i) begin
          scan_d = '0;
        end
      end
      ST_READ: begin
        state_d = (scan_q < count_q) ? ST_EVAL : ST_IDLE;
      end
      ST_EVAL: begin
        state_d = ST_READ;
        scan_d  = scan_q + CW'(1);
        if (scan_q == '0) begin
          // header hunt
          if (mem_rdata == header_q) begin
            sum_d = 16'(mem_rdata);
          end else begin
            drop_en = 1'b1;
          end
        end else if (scan_q == CW'(OffTarget)) begin
          if (mem_rdata == target_q) sum_d = sum_q + 16'(mem_rdata);
          else drop_en = 1'b1;
        end else if (scan_q == CW'(OffSource)) begin
          if (mem_rdata == source_q) sum_d = sum_q + 16'(mem_rdata);
          else drop_en = 1'b1;
        end else if (scan_q == CW'(OffClass)) begin
          class_d = mem_rdata;
          sum_d   = sum_q + 16'(mem_rdata);
        end else if (scan_q == CW'(OffSub)) begin
          sub_d = mem_rdata;
          sum_d = sum_q + 16'(mem_rdata);
        end else if (scan_q == CW'(OffLen)) begin
          if ((mem_rdata > {2'b00, limit_q}) || (mem_rdata > MaxPayByte)) begin
            drop_en = 1'b1;
          end else begin
            len_d = mem_rdata;
            sum_d = sum_q + 16'(mem_rdata);
          end
        end else if (scan_q < tail_k) begin
          sum_d = sum_q + 16'(mem_rdata);
        end else if (scan_q == tail_k) begin
          if (mem_rdata == tail_q) sum_d = sum_q + 16'(mem_rdata);
          else drop_en = 1'b1;
        end else if (scan_q == tail_k + CW'(1)) begin
          cklo_d = mem_rdata;
        end else begin
          // checksum high byte closes the frame
          if ({mem_rdata, cklo_q} == sum_q) begin
            idx_d   = '0;
            state_d = ST_EMIT_RD;
          end else begin
            drop_en = 1'b1;
          end
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (emit_last) begin
            drop_en = 1'b1;
            drop_n  = CW'(len_q) + CW'(FrameOvh);
            state_d = ST_READ;
          end else begin
            idx_d   = idx_q + 8'd1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // release bytes from the front and restart the parse there
    if (drop_en) begin
      base_d  = wrap_ptr({1'b0, base_q} + (PW+1)'(drop_n));
      count_d = count_q - drop_n;
      scan_d  = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      header_q    <= HEADER_RST;
      tail_q      <= TAIL_RST;
      target_q    <= TARGET_RST;
      source_q    <= SOURCE_RST;
      limit_q     <= LIMIT_RST;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_HEADER: header_q <= cfg_data_i;
          CFG_TAIL:   tail_q   <= cfg_data_i;
          CFG_TARGET: target_q <= cfg_data_i;
          CFG_SOURCE: source_q <= cfg_data_i;
          CFG_LIMIT:  limit_q  <= cfg_data_i[LenW-1:0];
          default:    ;
        endcase
      end
    end
  end

  // frame fields and running checksum
  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    class_q <= class_d;
    sub_q   <= sub_d;
    len_q   <= len_d;
    cklo_q  <= cklo_d;
    idx_q   <= idx_d;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_class_q <= class_q;
      out_sub_q   <= sub_q;
      out_len_q   <= len_q[LenW-1:0];
      out_idx_q   <= idx_q[LenW-1:0];
      out_byte_q  <= (len_q == '0) ? '0 : mem_rdata;
      out_empty_q <= (len_q == '0);
      out_last_q  <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_byte_q, out_idx_q, out_len_q, out_sub_q, out_class_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_empty_q;

`include "serial_frame_deframer_assert.svh"

  `SFD_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(Depth), "byte store overfilled")
  `SFD_ASSERT(a_scan_in_store, scan_q <= count_q, "parse position beyond stored bytes")
  `SFD_ASSERT(a_accept_room, in_xfer |-> (count_q < CW'(Depth)), "byte taken into a full store")
  `SFD_ASSERT(a_marker_last, (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> m_axis_tlast_o,
              "empty marker not flagged last")

endmodule

@@ tb/serial_frame_deframer_tb.sv @@
`timescale 1ns / 100ps

module serial_frame_deframer_tb;
  import sfd_pkg::*;

  localparam int MaxPayload  = 60;
  localparam int StoreDepth  = MaxPayload + FrameOvh;
  localparam int SettleCycles = 2000;

  // one payload item as it leaves the block
  typedef struct packed {
    logic [7:0] class_code;
    logic [7:0] sub_code;
    logic [5:0] payload_length;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       empty_marker;
    logic       last_of_frame;
  } frame_item_t;

  typedef enum int {
    FLAW_NONE   = 0,
    FLAW_TARGET = 1,
    FLAW_SOURCE = 2,
    FLAW_LENGTH = 3,
    FLAW_TAIL   = 4,
    FLAW_SUM    = 5
  } frame_flaw_e;

  typedef enum int {
    FRONT_WAIT,
    FRONT_REJECT,
    FRONT_ACCEPT
  } front_verdict_e;

  // one row of the directed table
  typedef struct {
    logic [7:0]  rx;
    bit          typed;
    int          n;
    frame_item_t want [2];
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [ByteW-1:0]    cfg_data_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [ByteW-1:0]    s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [TdataW-1:0]   m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic [TuserW-1:0]   m_axis_tuser_o;

  serial_frame_deframer #(
    .MAX_PAYLOAD(MaxPayload)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // current register settings, mirrored
  logic [7:0] hdr_val  = HEADER_RST;
  logic [7:0] tail_val = TAIL_RST;
  logic [7:0] tgt_addr = TARGET_RST;
  logic [7:0] src_addr = SOURCE_RST;
  logic [5:0] len_limit = LIMIT_RST;

  // mirrored byte store of the deframer
  logic [7:0]  held [StoreDepth];
  int          held_cnt = 0;
  logic [15:0] held_sum = '0;

  frame_item_t items_now [$];
  frame_item_t pending_items [$];

  int bytes_sent      = 0;
  int items_predicted = 0;
  int mismatches      = 0;
  int stall_left      = 0;
  bit src_gaps_on     = 1'b1;
  bit sink_stalls_on  = 1'b1;
  bit gaps_allowed    = 1'b1;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // sum over header through tail, as far as held
  function automatic void resum_held();
    int lim;
    lim = held_cnt;
    if (held_cnt >= OffPayload && int'(held[OffLen]) + 7 < lim) lim = int'(held[OffLen]) + 7;
    held_sum = '0;
    for (int i = 0; i < lim; i++) held_sum = held_sum + 16'(held[i]);
  endfunction

  function automatic void drop_lead(int n);
    if (n > held_cnt) n = held_cnt;
    for (int i = 0; i < held_cnt - n; i++) held[i] = held[i + n];
    held_cnt = held_cnt - n;
    resum_held();
  endfunction

  // judge the candidate frame at the front of the store
  function automatic front_verdict_e judge_front();
    int          len;
    logic [15:0] got;
    if (held_cnt > OffTarget && held[OffTarget] != tgt_addr) return FRONT_REJECT;
    if (held_cnt > OffSource && held[OffSource] != src_addr) return FRONT_REJECT;
    if (held_cnt <= OffLen) return FRONT_WAIT;
    len = int'(held[OffLen]);
    if (len > int'(len_limit) || len > MaxPayload) return FRONT_REJECT;
    if (held_cnt < len + 7) return FRONT_WAIT;
    if (held[len + 6] != tail_val) return FRONT_REJECT;
    if (held_cnt < len + 9) return FRONT_WAIT;
    got = {held[len + 8], held[len + 7]};
    return (got == held_sum) ? FRONT_ACCEPT : FRONT_REJECT;
  endfunction

  function automatic frame_item_t frame_item(int idx, logic [7:0] val, bit empty, bit last);
    frame_item_t it;
    it.class_code     = held[OffClass];
    it.sub_code       = held[OffSub];
    it.payload_length = held[OffLen][5:0];
    it.byte_index     = 6'(idx);
    it.payload_byte   = val;
    it.empty_marker   = empty;
    it.last_of_frame  = last;
    return it;
  endfunction

  // take one received byte, collect the payload items it releases
  function automatic void deframe_byte(input logic [7:0] b);
    int             skip;
    int             len;
    bit             busy;
    front_verdict_e v;
    items_now.delete();
    if (held_cnt >= StoreDepth) drop_lead(1);
    held[held_cnt] = b;
    held_cnt++;
    resum_held();
    busy = 1'b1;
    while (busy) begin
      skip = 0;
      while (skip < held_cnt && held[skip] != hdr_val) skip++;
      if (skip > 0) drop_lead(skip);
      if (held_cnt == 0) begin
        busy = 1'b0;
      end else begin
        v = judge_front();
        if (v == FRONT_WAIT) begin
          busy = 1'b0;
        end else if (v == FRONT_REJECT) begin
          drop_lead(1);
        end else begin
          len = int'(held[OffLen]);
          if (len == 0) begin
            items_now.push_back(frame_item(0, 8'h00, 1'b1, 1'b1));
          end else begin
            for (int i = 0; i < len; i++)
              items_now.push_back(frame_item(i, held[OffPayload + i], 1'b0, i == len - 1));
          end
          drop_lead(len + FrameOvh);
        end
      end
    end
  endfunction

  function automatic string item_text(frame_item_t it);
    return $sformatf("class=%02h sub=%02h len=%0d idx=%0d byte=%02h empty=%0b last=%0b",
                     it.class_code, it.sub_code, it.payload_length, it.byte_index,
                     it.payload_byte, it.empty_marker, it.last_of_frame);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic frame_item_t empty_marker_item(logic [7:0] cls, logic [7:0] sub);
    frame_item_t it;
    it = '0;
    it.class_code    = cls;
    it.sub_code      = sub;
    it.empty_marker  = 1'b1;
    it.last_of_frame = 1'b1;
    return it;
  endfunction

  function automatic logic [7:0] flip_mask();
    return 8'($urandom_range(1, 255));
  endfunction

  // mostly short payloads, now and then up to the limit
  function automatic int pick_len();
    int short_max;
    short_max = (len_limit < 5) ? int'(len_limit) : 5;
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, int'(len_limit));
    return $urandom_range(0, short_max);
  endfunction

  // receiver: random stall bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= (stall_left == 1);
    end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 13);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // compare each payload transfer with the oldest expectation
  always @(posedge clk_i) begin
    frame_item_t got;
    frame_item_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.class_code     = m_axis_tdata_o[7:0];
      got.sub_code       = m_axis_tdata_o[15:8];
      got.payload_length = m_axis_tdata_o[21:16];
      got.byte_index     = m_axis_tdata_o[27:22];
      got.payload_byte   = m_axis_tdata_o[35:28];
      got.empty_marker   = m_axis_tuser_o[0];
      got.last_of_frame  = m_axis_tlast_o;
      if (pending_items.size() == 0) begin
        note_mismatch({"unexpected transfer: ", item_text(got)});
      end else begin
        want = pending_items.pop_front();
        if (got !== want)
          note_mismatch({"mismatch: expected ", item_text(want), " got ", item_text(got)});
      end
    end
  end

  // hand one byte over, with an optional gap first
  task automatic offer_byte(input logic [7:0] b);
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    offer_byte(b);
    deframe_byte(b);
    foreach (items_now[i]) pending_items.push_back(items_now[i]);
    items_predicted += items_now.size();
  endtask

  // one frame under the current settings, optionally broken
  task automatic send_frame(input frame_flaw_e flaw, input int len);
    logic [7:0]  fb [$];
    logic [15:0] csum;
    fb.push_back(hdr_val);
    fb.push_back(flaw == FLAW_TARGET ? tgt_addr ^ flip_mask() : tgt_addr);
    fb.push_back(flaw == FLAW_SOURCE ? src_addr ^ flip_mask() : src_addr);
    fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    if (flaw == FLAW_LENGTH) begin
      // over-long length, rejected as soon as it is held
      fb.push_back(8'($urandom_range(int'(len_limit) + 1, 255)));
    end else begin
      fb.push_back(8'(len));
      repeat (len) fb.push_back(8'($urandom));
      fb.push_back(flaw == FLAW_TAIL ? tail_val ^ flip_mask() : tail_val);
      csum = '0;
      foreach (fb[i]) csum = csum + 16'(fb[i]);
      if (flaw == FLAW_SUM) csum = csum ^ 16'($urandom_range(1, 65535));
      fb.push_back(csum[7:0]);
      fb.push_back(csum[15:8]);
    end
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  // hold input until every expected item is out
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_items.size() != 0) @(posedge clk_i);
  endtask

  // drain, then let a possible rescan run out
  task automatic settle();
    drain();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] hdr, input logic [7:0] tail,
                              input logic [7:0] tgt, input logic [7:0] src,
                              input logic [5:0] lim);
    logic [CfgIdxW-1:0] regs [5];
    logic [7:0]         vals [5];
    regs = '{CFG_HEADER, CFG_TAIL, CFG_TARGET, CFG_SOURCE, CFG_LIMIT};
    vals = '{hdr, tail, tgt, src, {2'b00, lim}};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    hdr_val   = hdr;
    tail_val  = tail;
    tgt_addr  = tgt;
    src_addr  = src;
    len_limit = lim;
  endtask

  // directed table under reset settings
  task automatic run_directed();
    logic [7:0] too_long [6];
    logic [7:0] nested [25];
    stim_row_t  rows [$];
    stim_row_t  r;
    // length 61 is above the limit and is rejected on the length byte
    too_long = '{HEADER_RST, TARGET_RST, SOURCE_RST, 8'h00, 8'h00, 8'h3D};
    // outer frame of length 18 holds two empty frames and a bad tail;
    // both inner frames come out on the bad tail byte, the trailing
    // zero is then dropped as a byte ahead of any header
    // inner checksum: 223+151+1+255+0+0+253 = 0x0373
    nested = '{HEADER_RST, TARGET_RST, SOURCE_RST, 8'h00, 8'hFF, 8'h12,
               HEADER_RST, TARGET_RST, SOURCE_RST, 8'hFF, 8'h00, 8'h00, TAIL_RST,
               8'h73, 8'h03,
               HEADER_RST, TARGET_RST, SOURCE_RST, 8'h00, 8'hFF, 8'h00, TAIL_RST,
               8'h73, 8'h03,
               8'h00};
    r.want[0] = '0;
    r.want[1] = '0;
    foreach (too_long[i]) begin
      r.rx    = too_long[i];
      r.typed = 1'b1;
      r.n     = 0;
      rows.push_back(r);
    end
    foreach (nested[i]) begin
      r.rx    = nested[i];
      r.typed = (i == 24);
      r.n     = (i == 24) ? 2 : 0;
      r.want[0] = empty_marker_item(8'hFF, 8'h00);
      r.want[1] = empty_marker_item(8'h00, 8'hFF);
      rows.push_back(r);
    end
    foreach (rows[k]) begin
      offer_byte(rows[k].rx);
      deframe_byte(rows[k].rx);
      if (rows[k].typed) begin
        for (int j = 0; j < rows[k].n; j++) pending_items.push_back(rows[k].want[j]);
        items_predicted += rows[k].n;
      end else begin
        foreach (items_now[j]) pending_items.push_back(items_now[j]);
        items_predicted += items_now.size();
      end
    end
  endtask

  // well-formed frames with random content, broken frames and noise
  task automatic run_random(input int min_bytes, input int min_items);
    int b0;
    int i0;
    int pick;
    b0 = bytes_sent;
    i0 = items_predicted;
    while ((bytes_sent - b0 < min_bytes || items_predicted - i0 < min_items)
           && bytes_sent - b0 < 800) begin
      if (gaps_allowed) begin
        src_gaps_on    = ($urandom_range(0, 3) != 0);
        sink_stalls_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(FLAW_NONE, pick_len());
      end else if (pick < 85) begin
        send_frame(frame_flaw_e'($urandom_range(FLAW_TARGET, FLAW_SUM)), pick_len());
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
      if ($urandom_range(0, 11) == 0) drain();
    end
  endtask

  // watchdog
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    run_directed();
    run_random(8, 1);

    // low extremes for header and source, full length range
    settle();
    write_config(8'h00, 8'hFF, 8'hFF, 8'h00, 6'd60);
    send_frame(FLAW_NONE, MaxPayload);

    // high extremes, only empty frames pass
    settle();
    write_config(8'hFF, 8'h00, 8'h00, 8'hFF, 6'd0);
    run_random(8, 1);

    // random settings
    settle();
    write_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 6'($urandom_range(1, MaxPayload)));
    run_random(8, 1);

    // random settings, no gaps and no stalls
    settle();
    write_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 6'($urandom_range(1, MaxPayload)));
    gaps_allowed   = 1'b0;
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    run_random(8, 1);

    settle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
